// File: hw/rtl/bsr_pkg.sv
// shared types and constants for the bmp 24-bit to rgb565 stream decoder
`timescale 1ns / 1ps

package bsr_pkg;

   // header layout
   localparam logic [31:0] HEADER_LEN = 32'd30;
   localparam logic [7:0]  SIG_B      = 8'h42;
   localparam logic [7:0]  SIG_M      = 8'h4D;
   localparam logic [15:0] DEPTH_24   = 16'd24;

   // header byte positions
   localparam logic [31:0] POS_SIG_M     = 32'd1;
   localparam logic [31:0] POS_OFFSET_B0 = 32'd10;
   localparam logic [31:0] POS_OFFSET_B1 = 32'd11;
   localparam logic [31:0] POS_OFFSET_B2 = 32'd12;
   localparam logic [31:0] POS_OFFSET_B3 = 32'd13;
   localparam logic [31:0] POS_WIDTH_LO  = 32'd18;
   localparam logic [31:0] POS_WIDTH_HI  = 32'd19;
   localparam logic [31:0] POS_HEIGHT_LO = 32'd22;
   localparam logic [31:0] POS_HEIGHT_HI = 32'd23;
   localparam logic [31:0] POS_DEPTH_LO  = 32'd28;
   localparam logic [31:0] POS_DEPTH_HI  = 32'd29;

   // config register reset values
   localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd320;
   localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd240;

   // output word packing
   localparam int COORD_W    = 18;
   localparam int COLOR_W    = 16;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X      = 2'd0,
      CSR_ORIGIN_Y      = 2'd1,
      CSR_SCREEN_WIDTH  = 2'd2,
      CSR_SCREEN_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_SKIP   = 3'd2,
      PH_PIXEL  = 3'd3,
      PH_PAD    = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PIXEL      = 3'd0,
      KIND_BAD_SIG    = 3'd1,
      KIND_BAD_DEPTH  = 3'd2,
      KIND_OFF_SCREEN = 3'd3,
      KIND_BAD_OFFSET = 3'd4
   } kind_type;

   // configuration as seen by the parser
   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic        off_screen;
   } cfg_type;

   // one input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } item_type;

   // one result word
   typedef struct packed {
      kind_type           kind;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } result_type;

endpackage

// File: hw/rtl/bsr_csr.sv
// configuration registers and origin check
`timescale 1ns / 1ps

module bsr_csr
   import bsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   logic [15:0] origin_x_ff, origin_x_in;
   logic [15:0] origin_y_ff, origin_y_in;
   logic [15:0] screen_width_ff, screen_width_in;
   logic [15:0] screen_height_ff, screen_height_in;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:      origin_x_in      = csr_wdata;
            CSR_ORIGIN_Y:      origin_y_in      = csr_wdata;
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default:           origin_x_in      = origin_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
      end else begin
         origin_x_ff      <= origin_x_in;
         origin_y_ff      <= origin_y_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // signed origin against unsigned screen size, 17-bit compare
   assign cfg.origin_x   = origin_x_ff;
   assign cfg.origin_y   = origin_y_ff;
   assign cfg.off_screen =
      ($signed({origin_x_ff[15], origin_x_ff}) >= $signed({1'b0, screen_width_ff})) ||
      ($signed({origin_y_ff[15], origin_y_ff}) >= $signed({1'b0, screen_height_ff}));

endmodule

// File: hw/rtl/bsr_in_reg.sv
// input register stage for file bytes
`timescale 1ns / 1ps

module bsr_in_reg
   import bsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       advance,
   output logic       item_valid,
   output item_type   item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // take a word when empty or when the held word moves on
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = '{data_byte: req_tdata, start_of_file: req_tuser};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: hw/rtl/bsr_parser.sv
// bmp header parser and pixel converter, one byte per advance
`timescale 1ns / 1ps

module bsr_parser
   import bsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output logic       emit,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] offset_ff, offset_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [1:0]  bip_ff, bip_in;
   logic [1:0]  pad_ff, pad_in;
   logic [7:0]  blue_ff, blue_in;
   logic [7:0]  green_ff, green_in;

   logic [7:0]         b;
   logic [31:0]        pos_inc;
   logic [15:0]        depth_full;
   logic [16:0]        col_inc;
   logic [16:0]        row_inc;
   logic [1:0]         pad_dec;
   logic [COORD_W-1:0] px;
   logic [COORD_W-1:0] py;
   logic [COLOR_W-1:0] color;

   assign b          = item.data_byte;
   assign pos_inc    = pos_ff + 32'd1;
   assign depth_full = {b, depth_ff[7:0]};
   assign col_inc    = {1'b0, col_ff} + 17'd1;
   assign row_inc    = {1'b0, row_ff} + 17'd1;
   assign pad_dec    = pad_ff - 2'd1;

   // screen position and packed color of the pixel closing on this byte
   assign px    = {{2{cfg.origin_x[15]}}, cfg.origin_x} + {2'b00, col_ff};
   assign py    = {{2{cfg.origin_y[15]}}, cfg.origin_y} + {2'b00, height_ff}
                  - 18'd1 - {2'b00, row_ff};
   assign color = {b[7:3], green_ff[7:2], blue_ff[7:3]};

   // next state and result
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      bip_in    = bip_ff;
      pad_in    = pad_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      emit      = 1'b0;
      result    = '{kind: KIND_PIXEL, pixel_x: '0, pixel_y: '0, color: '0, last: 1'b0};

      if (item.start_of_file) begin
         // restart: clear everything, then check origin and first signature byte
         pos_in    = '0;
         offset_in = '0;
         width_in  = '0;
         height_in = '0;
         depth_in  = '0;
         col_in    = '0;
         row_in    = '0;
         bip_in    = '0;
         pad_in    = '0;
         blue_in   = '0;
         green_in  = '0;
         phase_in  = PH_HEADER;
         if (cfg.off_screen) begin
            phase_in    = PH_DONE;
            emit        = 1'b1;
            result.kind = KIND_OFF_SCREEN;
         end else begin
            pos_in = 32'd1;
            if (b != SIG_B) begin
               phase_in    = PH_DONE;
               emit        = 1'b1;
               result.kind = KIND_BAD_SIG;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               pos_in = pos_inc;
               if (pos_ff == POS_SIG_M && b != SIG_M) begin
                  phase_in    = PH_DONE;
                  emit        = 1'b1;
                  result.kind = KIND_BAD_SIG;
               end
               if (pos_ff == POS_OFFSET_B0) offset_in[7:0]   = b;
               if (pos_ff == POS_OFFSET_B1) offset_in[15:8]  = b;
               if (pos_ff == POS_OFFSET_B2) offset_in[23:16] = b;
               if (pos_ff == POS_OFFSET_B3) offset_in[31:24] = b;
               if (pos_ff == POS_WIDTH_LO)  width_in[7:0]    = b;
               if (pos_ff == POS_WIDTH_HI)  width_in[15:8]   = b;
               if (pos_ff == POS_HEIGHT_LO) height_in[7:0]   = b;
               if (pos_ff == POS_HEIGHT_HI) height_in[15:8]  = b;
               if (pos_ff == POS_DEPTH_LO)  depth_in[7:0]    = b;
               // last header byte: depth, offset and area checks in that order
               if (pos_ff == POS_DEPTH_HI) begin
                  depth_in = depth_full;
                  if (depth_full != DEPTH_24) begin
                     phase_in    = PH_DONE;
                     emit        = 1'b1;
                     result.kind = KIND_BAD_DEPTH;
                  end else if (offset_ff < HEADER_LEN) begin
                     phase_in    = PH_DONE;
                     emit        = 1'b1;
                     result.kind = KIND_BAD_OFFSET;
                  end else if (width_ff == '0 || height_ff == '0) begin
                     phase_in = PH_DONE;
                  end else if (offset_ff == HEADER_LEN) begin
                     phase_in = PH_PIXEL;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               pos_in = pos_inc;
               if (pos_inc == offset_ff) phase_in = PH_PIXEL;
            end
            PH_PIXEL: begin
               unique case (bip_ff)
                  2'd0: begin
                     blue_in = b;
                     bip_in  = 2'd1;
                  end
                  2'd1: begin
                     green_in = b;
                     bip_in   = 2'd2;
                  end
                  default: begin
                     bip_in         = 2'd0;
                     emit           = 1'b1;
                     result.pixel_x = px;
                     result.pixel_y = py;
                     result.color   = color;
                     col_in         = col_inc[15:0];
                     if (col_inc >= {1'b0, width_ff}) begin
                        col_in = '0;
                        row_in = row_inc[15:0];
                        if (row_inc >= {1'b0, height_ff}) begin
                           result.last = 1'b1;
                           phase_in    = PH_DONE;
                        end else begin
                           // row pad is (-3w) mod 4, which equals w mod 4
                           pad_in = width_ff[1:0];
                           if (width_ff[1:0] != 2'd0) phase_in = PH_PAD;
                        end
                     end
                  end
               endcase
            end
            PH_PAD: begin
               if (pad_ff != 2'd0) pad_in = pad_dec;
               if (pad_ff <= 2'd1) phase_in = PH_PIXEL;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         offset_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         depth_ff  <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         bip_ff    <= '0;
         pad_ff    <= '0;
         blue_ff   <= '0;
         green_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         bip_ff    <= bip_in;
         pad_ff    <= pad_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
      end
   end

endmodule

// File: hw/rtl/bsr_out_reg.sv
// result register toward the pixel stream
`timescale 1ns / 1ps

module bsr_out_reg
   import bsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  emit,
   input  result_type            result,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // room for a new result when empty or when the held one is taken now
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (advance) begin
         valid_in  = emit;
         result_in = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 * COORD_W - COLOR_W){1'b0}},
                        result_ff.color, result_ff.pixel_y, result_ff.pixel_x};
   assign rsp_tuser  = result_ff.kind;
   assign rsp_tlast  = result_ff.last;

endmodule

// File: hw/rtl/bmp24_stream_to_rgb565.sv
// top level of the bmp 24-bit to rgb565 stream decoder
`timescale 1ns / 1ps

// Takes a BMP file one byte per word (req_tuser high on byte 0) and returns
// one RGB565 pixel word per blue, green, red triple, with its screen position,
// rows flipped bottom-up and row pad skipped. Error words (bad signature, depth
// not 24, origin off screen, data offset inside the 30-byte header) come once,
// after which the rest of the file is ignored. Throughput is one byte per
// clock while rsp_tready stays high: each byte passes an input register,
// combinational parser logic and a result register, and its result word is
// valid from the result register. A result word held by a low rsp_tready
// holds the parser, and the input stops taking bytes once the input register
// is also full. Write the csr registers only while no file bytes are in flight.

module bmp24_stream_to_rgb565
   import bsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] start_of_file
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [17:0] pixel_x, [35:18] pixel_y,
                                              // [51:36] color, [55:52] zero
   output logic [2:0]            rsp_tuser,   // [2:0] kind
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   cfg_type    cfg;
   item_type   item;
   result_type result;
   logic       item_valid;
   logic       out_free;
   logic       advance;
   logic       emit;

   // a byte moves through the parser when the result register has room
   assign advance = item_valid && out_free;

   bsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bsr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   bsr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .emit    (emit),
      .result  (result)
   );

   bsr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .emit       (emit),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // error words carry no position, color or last mark
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_PIXEL) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("error word with nonzero payload");

   // an accepted byte lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> item_valid)
      else $error("accepted byte lost");

   // a held byte that cannot advance is still held next cycle
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && !out_free) |=> item_valid)
      else $error("stalled byte dropped");

endmodule

// File: dv/bmp24_stream_to_rgb565_test.sv
// self-checking testbench for the bmp 24-bit to rgb565 stream decoder
`timescale 1ns / 1ps

module bmp24_stream_to_rgb565_test;
   import bsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_BYTES   = 100;

   // clock, reset and block ports
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index  = '0;
   logic [15:0]           csr_wdata  = '0;

   bmp24_stream_to_rgb565 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder settings as the parser should see them
   logic [15:0] cfg_origin_x = '0;
   logic [15:0] cfg_origin_y = '0;
   logic [15:0] cfg_screen_w = SCREEN_WIDTH_RST;
   logic [15:0] cfg_screen_h = SCREEN_HEIGHT_RST;

   // parser state of the predictor
   phase_type   parse_phase  = PH_IDLE;
   logic [31:0] file_pos     = '0;
   logic [31:0] pixel_offset = '0;
   logic [15:0] img_w        = '0;
   logic [15:0] img_h        = '0;
   logic [15:0] img_depth    = '0;
   logic [15:0] col_idx      = '0;
   logic [15:0] row_idx      = '0;
   logic [1:0]  rgb_step     = '0;
   logic [1:0]  pad_left     = '0;
   logic [7:0]  blue_keep    = '0;
   logic [7:0]  green_keep   = '0;

   // words the decoder still owes, oldest first
   result_type  decoded_words[$];
   logic [7:0]  file_bytes[$];

   int  fail_count     = 0;
   int  bytes_sent     = 0;
   int  files_sent     = 0;
   int  pixels_checked = 0;
   int  errors_checked = 0;
   int  settings_used  = 1;
   int  stall_left     = 0;
   int  quiet_cycles   = 0;
   bit  sender_steady  = 1'b0;
   bit  rsp_steady     = 1'b0;

   // work out the word, if any, that one accepted byte produces
   function automatic void decode_byte(input logic [7:0] b, input logic sof);
      result_type  word;
      logic [31:0] p;
      logic        emit;
      int          px;
      int          py;
      word = '0;
      emit = 1'b0;
      if (sof) begin
         file_pos     = '0;
         pixel_offset = '0;
         img_w        = '0;
         img_h        = '0;
         img_depth    = '0;
         col_idx      = '0;
         row_idx      = '0;
         rgb_step     = '0;
         pad_left     = '0;
         blue_keep    = '0;
         green_keep   = '0;
         parse_phase  = PH_HEADER;
         if (int'($signed(cfg_origin_x)) >= int'(cfg_screen_w) ||
             int'($signed(cfg_origin_y)) >= int'(cfg_screen_h)) begin
            parse_phase = PH_DONE;
            word.kind = KIND_OFF_SCREEN;
            decoded_words.push_back(word);
            return;
         end
      end
      case (parse_phase)
         PH_HEADER: begin
            p = file_pos;
            file_pos = p + 1;
            if ((p == 0 && b != SIG_B) || (p == POS_SIG_M && b != SIG_M)) begin
               parse_phase = PH_DONE;
               word.kind = KIND_BAD_SIG;
               emit = 1'b1;
            end else begin
               case (p)
                  POS_OFFSET_B0: pixel_offset[7:0]   = b;
                  POS_OFFSET_B1: pixel_offset[15:8]  = b;
                  POS_OFFSET_B2: pixel_offset[23:16] = b;
                  POS_OFFSET_B3: pixel_offset[31:24] = b;
                  POS_WIDTH_LO:  img_w[7:0]          = b;
                  POS_WIDTH_HI:  img_w[15:8]         = b;
                  POS_HEIGHT_LO: img_h[7:0]          = b;
                  POS_HEIGHT_HI: img_h[15:8]         = b;
                  POS_DEPTH_LO:  img_depth[7:0]      = b;
                  POS_DEPTH_HI: begin
                     img_depth[15:8] = b;
                     // depth beats offset beats zero area
                     if (img_depth != DEPTH_24) begin
                        parse_phase = PH_DONE;
                        word.kind = KIND_BAD_DEPTH;
                        emit = 1'b1;
                     end else if (pixel_offset < HEADER_LEN) begin
                        parse_phase = PH_DONE;
                        word.kind = KIND_BAD_OFFSET;
                        emit = 1'b1;
                     end else if (img_w == 0 || img_h == 0) begin
                        parse_phase = PH_DONE;
                     end else begin
                        parse_phase = (pixel_offset == HEADER_LEN) ? PH_PIXEL : PH_SKIP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         PH_SKIP: begin
            file_pos = file_pos + 1;
            if (file_pos == pixel_offset) parse_phase = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (rgb_step == 2'd0) begin
               blue_keep = b;
               rgb_step = 2'd1;
            end else if (rgb_step == 2'd1) begin
               green_keep = b;
               rgb_step = 2'd2;
            end else begin
               rgb_step = 2'd0;
               word.kind = KIND_PIXEL;
               word.color = {b[7:3], green_keep[7:2], blue_keep[7:3]};
               px = int'($signed(cfg_origin_x)) + int'(col_idx);
               py = int'($signed(cfg_origin_y)) + int'(img_h) - 1 - int'(row_idx);
               word.pixel_x = px[COORD_W-1:0];
               word.pixel_y = py[COORD_W-1:0];
               col_idx = col_idx + 1;
               // end of row: flip to next row, maybe skip pad
               if (col_idx >= img_w) begin
                  col_idx = '0;
                  row_idx = row_idx + 1;
                  if (row_idx >= img_h) begin
                     word.last = 1'b1;
                     parse_phase = PH_DONE;
                  end else begin
                     pad_left = 2'((4 - ((int'(img_w) * 3) & 3)) & 3);
                     if (pad_left != 0) parse_phase = PH_PAD;
                  end
               end
               emit = 1'b1;
            end
         end
         PH_PAD: begin
            if (pad_left > 0) pad_left = pad_left - 1;
            if (pad_left == 0) parse_phase = PH_PIXEL;
         end
         default: ;
      endcase
      if (emit) decoded_words.push_back(word);
   endfunction

   // compare one result word with the oldest one owed
   function automatic void check_word();
      result_type want;
      if (decoded_words.size() == 0) begin
         $error("unexpected word: kind %0d data %h last %b", rsp_tuser, rsp_tdata, rsp_tlast);
         fail_count++;
      end else begin
         want = decoded_words.pop_front();
         if (rsp_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
            fail_count++;
         end
         if (rsp_tdata[17:0] !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", $signed(want.pixel_x),
                   $signed(rsp_tdata[17:0]));
            fail_count++;
         end
         if (rsp_tdata[35:18] !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", $signed(want.pixel_y),
                   $signed(rsp_tdata[35:18]));
            fail_count++;
         end
         if (rsp_tdata[51:36] !== want.color) begin
            $error("color: expected %h, got %h", want.color, rsp_tdata[51:36]);
            fail_count++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, rsp_tlast);
            fail_count++;
         end
         if (want.kind == KIND_PIXEL) pixels_checked++;
         else errors_checked++;
      end
   endfunction

   // result side: check accepted words, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_word();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (rsp_steady || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2);
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("** bmp24_stream_to_rgb565: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_steady || roll < 75) return 0;
      if (roll < 96) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // send one byte and wait for its handshake
   task automatic send_byte(input logic [7:0] b, input logic sof);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b, sof);
      bytes_sent++;
   endtask

   task automatic idle_gap();
      int n;
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off the sender until every owed word is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (decoded_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers while the decoder is idle
   task automatic configure(input logic [15:0] ox, oy, sw, sh);
      logic [15:0] vals [4];
      vals = '{ox, oy, sw, sh};
      drain();
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (csr_index_type'(i))
            CSR_ORIGIN_X:      cfg_origin_x = vals[i];
            CSR_ORIGIN_Y:      cfg_origin_y = vals[i];
            CSR_SCREEN_WIDTH:  cfg_screen_w = vals[i];
            CSR_SCREEN_HEIGHT: cfg_screen_h = vals[i];
         endcase
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // 30-byte header with random filler around the parsed fields
   function automatic void make_header(input logic [31:0] width_word, height_word, offset,
                                       input logic [15:0] depth,
                                       input logic [7:0] sig0 = SIG_B,
                                       input logic [7:0] sig1 = SIG_M);
      file_bytes.delete();
      for (int i = 0; i < 30; i++) file_bytes.push_back(8'($urandom));
      file_bytes[0] = sig0;
      file_bytes[POS_SIG_M] = sig1;
      for (int i = 0; i < 4; i++) begin
         file_bytes[POS_OFFSET_B0 + i] = offset[8*i +: 8];
         file_bytes[POS_WIDTH_LO + i]  = width_word[8*i +: 8];
         file_bytes[POS_HEIGHT_LO + i] = height_word[8*i +: 8];
      end
      file_bytes[POS_DEPTH_LO] = depth[7:0];
      file_bytes[POS_DEPTH_HI] = depth[15:8];
   endfunction

   // gap before pixels, rows with their pad, then trailing junk
   function automatic void add_body(input int w, skip, rows, tail);
      for (int i = 0; i < skip; i++) file_bytes.push_back(8'($urandom));
      for (int r = 0; r < rows; r++) begin
         for (int i = 0; i < w * 3; i++) file_bytes.push_back(pick_byte());
         for (int i = 0; i < ((4 - ((w * 3) & 3)) & 3); i++)
            file_bytes.push_back(8'($urandom));
      end
      for (int i = 0; i < tail; i++) file_bytes.push_back(8'($urandom));
   endfunction

   task automatic send_bytes(input int count, input bit with_start);
      for (int i = 0; i < count && i < file_bytes.size(); i++) begin
         send_byte(file_bytes[i], with_start && i == 0);
         idle_gap();
      end
      if (with_start) files_sent++;
   endtask

   // well-formed file, width and height upper halves sometimes junk
   task automatic send_image(input int w, h, skip);
      logic [15:0] w_hi;
      logic [15:0] h_hi;
      w_hi = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
      h_hi = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
      make_header({w_hi, 16'(w)}, {h_hi, 16'(h)}, 32'(30 + skip), DEPTH_24);
      add_body(w, skip, h, $urandom_range(0, 3));
      send_bytes(file_bytes.size(), 1'b1);
   endtask

   // bytes before any start mark are ignored
   task automatic test_bytes_without_start();
      file_bytes.delete();
      for (int i = 0; i < 6; i++) file_bytes.push_back(pick_byte());
      send_bytes(6, 1'b0);
   endtask

   // every row pad length, skipped gaps, one-pixel image, zero area
   task automatic test_image_shapes();
      send_image(1, 1, 0);
      send_image(2, 2, 4);
      send_image(3, 2, 1);
      send_image(4, 2, 0);
      make_header(32'd0, 32'd3, 32'd30, DEPTH_24);
      send_bytes(file_bytes.size(), 1'b1);
      make_header(32'd3, 32'd0, 32'd30, DEPTH_24);
      send_bytes(file_bytes.size(), 1'b1);
   endtask

   // signature, depth and offset errors, and their order
   task automatic test_header_errors();
      make_header(32'd2, 32'd2, 32'd30, DEPTH_24, 8'h43, SIG_M);
      send_bytes(4, 1'b1);
      make_header(32'd2, 32'd2, 32'd30, DEPTH_24, SIG_B, 8'h4E);
      send_bytes(4, 1'b1);
      make_header(32'd2, 32'd1, 32'd30, 16'd32);
      send_bytes(file_bytes.size(), 1'b1);
      make_header(32'd2, 32'd1, 32'd30, 16'h0118);
      send_bytes(file_bytes.size(), 1'b1);
      make_header(32'd2, 32'd1, 32'd29, DEPTH_24);
      send_bytes(file_bytes.size(), 1'b1);
      make_header(32'd2, 32'd1, 32'd0, 16'd8);
      send_bytes(file_bytes.size(), 1'b1);
      make_header(32'd0, 32'd0, 32'd0, DEPTH_24);
      send_bytes(file_bytes.size(), 1'b1);
      // offset far past the data: everything after the header is skipped
      make_header(32'd2, 32'd2, 32'hFF00_001E, DEPTH_24);
      add_body(2, 0, 1, 0);
      send_bytes(file_bytes.size(), 1'b1);
   endtask

   // a start mark in the middle of a file restarts the parser
   task automatic test_restart();
      make_header(32'd3, 32'd3, 32'd30, DEPTH_24);
      add_body(3, 0, 3, 0);
      send_bytes(34, 1'b1);
      make_header(32'd2, 32'd2, 32'd31, DEPTH_24);
      add_body(2, 1, 2, 0);
      send_bytes(12, 1'b1);
      send_image(2, 2, 1);
   endtask

   // origin and screen extremes, on and off screen
   task automatic test_origin_extremes();
      configure(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
      send_image(2, 1, 0);
      // largest image: only the first pixels of its first row
      configure(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      make_header(32'hFFFF, 32'hFFFF, 32'd30, DEPTH_24);
      add_body(4, 0, 1, 0);
      send_bytes(42, 1'b1);
      send_image(1, 1, 0);
      configure(16'h8000, 16'h7FFF, 16'd1, 16'hFFFF);
      make_header(32'd2, 32'hFFFF, 32'd30, DEPTH_24);
      add_body(2, 0, 2, 0);
      send_bytes(46, 1'b1);
      configure(16'd320, 16'd0, 16'd320, 16'd240);
      send_image(1, 1, 0);
      configure(16'd0, 16'd240, 16'd320, 16'd240);
      send_image(1, 1, 0);
      configure(16'd319, 16'd239, 16'd320, 16'd240);
      send_image(1, 1, 0);
      configure(16'd0, 16'd0, 16'd1, 16'd1);
      send_image(1, 1, 0);
      configure(16'd1, 16'd0, 16'd1, 16'd1);
      send_image(1, 1, 0);
      configure(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
      send_image(1, 1, 0);
      configure(16'd0, 16'd0, SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
   endtask

   task automatic random_setting();
      logic [15:0] sw;
      logic [15:0] sh;
      logic [15:0] ox;
      logic [15:0] oy;
      sw = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 400));
      sh = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 400));
      ox = ($urandom_range(0, 9) == 0) ? 16'($urandom)
           : 16'(int'($urandom_range(0, sw - 1)) - int'($urandom_range(0, 64)));
      oy = ($urandom_range(0, 9) == 0) ? 16'($urandom)
           : 16'(int'($urandom_range(0, sh - 1)) - int'($urandom_range(0, 64)));
      configure(ox, oy, sw, sh);
   endtask

   // mostly well-formed files with random content, some broken ones
   task automatic test_random_files();
      int start_bytes;
      int ignored;
      int nfiles;
      int roll;
      int w;
      int h;
      start_bytes = bytes_sent;
      ignored = 0;
      nfiles = 0;
      while (bytes_sent - start_bytes - ignored < RANDOM_BYTES) begin
         if (nfiles % 4 == 0) random_setting();
         if (nfiles == 1) drain();
         sender_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         w = $urandom_range(1, 5);
         h = $urandom_range(1, 3);
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            send_image(w, h, $urandom_range(0, 5));
         end else if (roll < 78) begin
            // cut short by the next start mark
            make_header(32'(w), 32'(h), 32'd30, DEPTH_24);
            add_body(w, 0, h, 0);
            send_bytes($urandom_range(1, file_bytes.size() - 1), 1'b1);
         end else if (roll < 84) begin
            make_header(32'(w), 32'(h), 32'd30, DEPTH_24, pick_byte(), pick_byte());
            add_body(w, 0, 1, 0);
            send_bytes(file_bytes.size(), 1'b1);
         end else if (roll < 88) begin
            make_header(32'(w), 32'(h), 32'($urandom), 16'($urandom));
            add_body(w, 0, 1, 0);
            send_bytes(file_bytes.size(), 1'b1);
         end else if (roll < 92) begin
            make_header(32'(w), 32'(h), 32'($urandom_range(0, 29)), DEPTH_24);
            add_body(w, 0, 1, 0);
            send_bytes(file_bytes.size(), 1'b1);
         end else if (roll < 96) begin
            make_header(roll[0] ? 32'd0 : 32'(w), roll[0] ? 32'(h) : 32'd0, 32'd30, DEPTH_24);
            add_body(w, 0, 1, 0);
            send_bytes(file_bytes.size(), 1'b1);
         end else begin
            file_bytes.delete();
            for (int i = 0; i < 5; i++) file_bytes.push_back(pick_byte());
            send_bytes(5, 1'b0);
            ignored += 5;
         end
         nfiles++;
      end
      sender_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bytes_without_start();
      test_image_shapes();
      test_header_errors();
      test_restart();
      test_origin_extremes();
      test_random_files();
      drain();
      $display("sent %0d bytes in %0d files under %0d register settings",
               bytes_sent, files_sent, settings_used);
      $display("checked %0d pixel words and %0d error words", pixels_checked, errors_checked);
      if (fail_count == 0) begin
         $display("** bmp24_stream_to_rgb565: PASSED **");
      end else begin
         $display("** bmp24_stream_to_rgb565: FAILED **");
      end
      $finish;
   end

endmodule

// File: bmp24_stream_to_rgb565.f
hw/rtl/bsr_pkg.sv
hw/rtl/bsr_csr.sv
hw/rtl/bsr_in_reg.sv
hw/rtl/bsr_parser.sv
hw/rtl/bsr_out_reg.sv
hw/rtl/bmp24_stream_to_rgb565.sv
dv/bmp24_stream_to_rgb565_test.sv
